// File: rtl/core/tetci_pkg.sv
package tetci_pkg;

  localparam int IMAGE_SIZE = 512;
  localparam int COORD_BITS = 12;
  localparam int PIX_W      = 9;
  localparam int CH_W       = 8;
  localparam int REG_W      = 24;
  localparam int IDX_W      = 3;

  // difference of a pixel coordinate and a vertex coordinate, signed
  localparam int DIFF_W = ((COORD_BITS > PIX_W) ? COORD_BITS : PIX_W + 1) + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int EDGE_W = PROD_W + 1;
  // edge magnitude once the pixel is known covered
  localparam int EU_W   = EDGE_W - 1;
  localparam int TOT_W  = EU_W + 2;
  localparam int MUL_W  = EU_W + CH_W;
  localparam int NUM_W  = EU_W + CH_W + 2;

  typedef enum logic [IDX_W-1:0] {
    REG_VERTEX_A = 3'd0,
    REG_VERTEX_B = 3'd1,
    REG_VERTEX_C = 3'd2,
    REG_COLOR_A  = 3'd3,
    REG_COLOR_B  = 3'd4,
    REG_COLOR_C  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_word_t;

  typedef struct packed {
    logic            covered;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } res_word_t;

endpackage

// File: rtl/core/triangle_edge_test_color_interp_unit.sv
// An accepted pixel word reaches its result word through the pipeline stages
// (4 stages of edge setup and blend products, 1 sum stage, 8 divide stages).
// Throughput: one pixel per cycle while the output is not stalled; each divide stage retires one quotient bit.
// A stalled output backs up stage by stage, empty stages keep filling.
// Reset (rst, synchronous) clears all vertex and color registers and the
// stage valid bits.
module triangle_edge_test_color_interp_unit
  import tetci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  pix_word_t        pix_word,
  output logic             res_valid,
  input  logic             res_stall,
  output res_word_t        res_word
);

  localparam int NSTG = 5 + CH_W;

  // configuration
  logic [REG_W-1:0] vertex_a, vertex_b, vertex_c;
  logic [REG_W-1:0] color_of_a, color_of_b, color_of_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a   <= '0;
      vertex_b   <= '0;
      vertex_c   <= '0;
      color_of_a <= '0;
      color_of_b <= '0;
      color_of_c <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_VERTEX_A: vertex_a   <= cfg_data;
        REG_VERTEX_B: vertex_b   <= cfg_data;
        REG_VERTEX_C: vertex_c   <= cfg_data;
        REG_COLOR_A:  color_of_a <= cfg_data;
        REG_COLOR_B:  color_of_b <= cfg_data;
        REG_COLOR_C:  color_of_c <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [COORD_BITS-1:0] vx[3], vy[3], vxn[3], vyn[3];
  logic [REG_W-1:0] col[3];

  always_comb begin
    vx[0] = signed'(vertex_a[2*COORD_BITS-1:COORD_BITS]);
    vx[1] = signed'(vertex_b[2*COORD_BITS-1:COORD_BITS]);
    vx[2] = signed'(vertex_c[2*COORD_BITS-1:COORD_BITS]);
    vy[0] = signed'(vertex_a[COORD_BITS-1:0]);
    vy[1] = signed'(vertex_b[COORD_BITS-1:0]);
    vy[2] = signed'(vertex_c[COORD_BITS-1:0]);
    // edge e runs from vertex e to the next one: AB, BC, CA
    vxn[0] = vx[1];
    vxn[1] = vx[2];
    vxn[2] = vx[0];
    vyn[0] = vy[1];
    vyn[1] = vy[2];
    vyn[2] = vy[0];
    col[0] = color_of_a;
    col[1] = color_of_b;
    col[2] = color_of_c;
  end

  // stage flow control
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !res_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign pix_stall = !rdy[0];
  assign res_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= pix_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: coordinate differences
  logic signed [DIFF_W-1:0] s0_dqx[3], s0_dy[3], s0_dqy[3], s0_dx[3];
  logic                     s0_on;
  logic signed [DIFF_W-1:0] px_s, py_s;

  assign px_s = DIFF_W'(signed'({1'b0, pix_word.pixel_x}));
  assign py_s = DIFF_W'(signed'({1'b0, pix_word.pixel_y}));

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int e = 0; e < 3; e++) begin
        s0_dqx[e] <= DIFF_W'(vxn[e]) - DIFF_W'(vx[e]);
        s0_dqy[e] <= DIFF_W'(vyn[e]) - DIFF_W'(vy[e]);
        s0_dy[e]  <= py_s - DIFF_W'(vy[e]);
        s0_dx[e]  <= px_s - DIFF_W'(vx[e]);
      end
      s0_on <= (int'(pix_word.pixel_x) < IMAGE_SIZE) && (int'(pix_word.pixel_y) < IMAGE_SIZE);
    end
  end

  // stage 1: cross products
  logic signed [PROD_W-1:0] s1_p1[3], s1_p2[3];
  logic                     s1_on;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int e = 0; e < 3; e++) begin
        s1_p1[e] <= PROD_W'(s0_dqx[e]) * PROD_W'(s0_dy[e]);
        s1_p2[e] <= PROD_W'(s0_dqy[e]) * PROD_W'(s0_dx[e]);
      end
      s1_on <= s0_on;
    end
  end

  // stage 2: edge values
  logic signed [EDGE_W-1:0] s2_e[3];
  logic                     s2_on;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int e = 0; e < 3; e++) begin
        s2_e[e] <= EDGE_W'(s1_p1[e]) - EDGE_W'(s1_p2[e]);
      end
      s2_on <= s1_on;
    end
  end

  // stage 3: coverage, color weights, doubled area
  logic [MUL_W-1:0] s3_m[3][3];
  logic [TOT_W-1:0] s3_tot;
  logic             s3_cov;
  logic [EU_W-1:0]  eu[3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      eu[e] = s2_e[e][EU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int e = 0; e < 3; e++) begin
        for (int c = 0; c < 3; c++) begin
          s3_m[e][c] <= MUL_W'(col[e][(2-c)*CH_W +: CH_W]) * MUL_W'(eu[e]);
        end
      end
      s3_tot <= TOT_W'(eu[0]) + TOT_W'(eu[1]) + TOT_W'(eu[2]);
      s3_cov <= s2_on && (s2_e[0] > 0) && (s2_e[1] > 0) && (s2_e[2] > 0);
    end
  end

  // stage 4: numerators
  logic [NUM_W-1:0] s4_num[3];
  logic [TOT_W-1:0] s4_tot;
  logic             s4_cov;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int c = 0; c < 3; c++) begin
        s4_num[c] <= NUM_W'(s3_m[0][c]) + NUM_W'(s3_m[1][c]) + NUM_W'(s3_m[2][c]);
      end
      s4_tot <= s3_tot;
      s4_cov <= s3_cov;
    end
  end

  // stages 5 and up: restoring divide, one quotient bit per stage, MSB first.
  // A covered pixel always gives a quotient below 256.
  logic [NUM_W-1:0] dv_rem[CH_W-1][3];
  logic [TOT_W-1:0] dv_tot[CH_W-1];
  logic [CH_W-1:0]  dv_q[CH_W][3];
  logic             dv_cov[CH_W];

  for (genvar j = 0; j < CH_W; j++) begin : g_div
    logic [NUM_W-1:0] src_rem[3];
    logic [CH_W-1:0]  src_q[3];
    logic [TOT_W-1:0] src_tot;
    logic             src_cov;
    logic [NUM_W-1:0] sh;
    logic             ge[3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          src_rem[c] = s4_num[c];
          src_q[c]   = '0;
        end
        src_tot = s4_tot;
        src_cov = s4_cov;
      end
    end else begin : g_next
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          src_rem[c] = dv_rem[j-1][c];
          src_q[c]   = dv_q[j-1][c];
        end
        src_tot = dv_tot[j-1];
        src_cov = dv_cov[j-1];
      end
    end

    assign sh = NUM_W'(src_tot) << (CH_W - 1 - j);

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        ge[c] = (src_rem[c] >= sh);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[5+j]) begin
        for (int c = 0; c < 3; c++) begin
          dv_q[j][c] <= {src_q[c][CH_W-2:0], ge[c]};
        end
        dv_cov[j] <= src_cov;
      end
    end

    if (j < CH_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (rdy[5+j]) begin
          for (int c = 0; c < 3; c++) begin
            dv_rem[j][c] <= ge[c] ? (src_rem[c] - sh) : src_rem[c];
          end
          dv_tot[j] <= src_tot;
        end
      end
    end
  end

  always_comb begin
    res_word.covered   = dv_cov[CH_W-1];
    res_word.out_red   = dv_cov[CH_W-1] ? dv_q[CH_W-1][0] : '0;
    res_word.out_green = dv_cov[CH_W-1] ? dv_q[CH_W-1][1] : '0;
    res_word.out_blue  = dv_cov[CH_W-1] ? dv_q[CH_W-1][2] : '0;
  end

endmodule
